### hdl/lrd_pkg.sv
// lrd_pkg: shared types and constants of the log record deframer
// used by lrd_crc, lrd_parser, the top level and the checker
`timescale 1ns / 1ps

package lrd_pkg;

  // header: checksum word, type word, length word
  localparam int unsigned HeaderBytes = 4 * 3;
  localparam int unsigned HdrCntW     = 4;
  localparam logic [31:0] Crc32cPoly  = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic CfgExpectedType = 1'b0;
  localparam logic CfgMaxRecordLen = 1'b1;

  typedef enum logic [2:0] {
    StNone     = 3'd0,
    StOk       = 3'd1,
    StBadType  = 3'd2,
    StCsumErr  = 3'd3,
    StEof      = 3'd4,
    StTooLong  = 3'd5
  } status_e;

  // one result word from the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       byte_valid;
    status_e    status;
    logic       record_end;
  } result_t;

endpackage

### hdl/lrd_crc.sv
// lrd_crc: one-byte update of a reflected crc-32c register
// depends on lrd_pkg for the polynomial
`timescale 1ns / 1ps

module lrd_crc import lrd_pkg::*; (
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'h0, byte_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ Crc32cPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

### hdl/lrd_parser.sv
// lrd_parser: header parse, payload crc and record status for one word per step
// depends on lrd_pkg and lrd_crc
`timescale 1ns / 1ps

module lrd_parser import lrd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_file_i,
  input  logic [31:0]   expected_type_i,
  input  logic [30:0]   max_record_length_i,
  output result_t       res_o
);

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhHalt    = 2'd2
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [31:0]        shift_q, shift_d;
  logic [31:0]        csum_q, csum_d;
  logic [30:0]        remain_q, remain_d;
  logic [31:0]        crc_q, crc_d;
  logic               mismatch_q, mismatch_d;

  logic [31:0]        shift_nx;
  logic [HdrCntW-1:0] cnt_nx;
  logic [31:0]        crc_nx;
  logic [30:0]        remain_nx;

  lrd_crc u_crc (
    .crc_i  (crc_q),
    .byte_i (in_byte_i),
    .crc_o  (crc_nx)
  );

  assign shift_nx  = {in_byte_i, shift_q[31:8]};
  assign cnt_nx    = hdr_cnt_q + HdrCntW'(1);
  assign remain_nx = remain_q - 31'd1;

  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    shift_d    = shift_q;
    csum_d     = csum_q;
    remain_d   = remain_q;
    crc_d      = crc_q;
    mismatch_d = mismatch_q;
    res_o      = '{valid: 1'b0, out_byte: 8'h00, byte_valid: 1'b0,
                   status: StNone, record_end: 1'b0};

    if (phase_q == PhHeader || phase_q == PhPayload) begin
      if (end_of_file_i) begin
        phase_d    = PhHeader;
        hdr_cnt_d  = '0;
        shift_d    = '0;
        mismatch_d = 1'b0;
        crc_d      = CrcInit;
        remain_d   = '0;
        res_o.valid      = 1'b1;
        res_o.status     = StEof;
        res_o.record_end = 1'b1;
      end else if (phase_q == PhHeader) begin
        shift_d   = shift_nx;
        hdr_cnt_d = cnt_nx;
        if (cnt_nx == HdrCntW'(4)) begin
          csum_d = shift_nx;
        end else if (cnt_nx == HdrCntW'(8)) begin
          mismatch_d = (shift_nx != expected_type_i);
        end else if (cnt_nx == HdrCntW'(HeaderBytes)) begin
          hdr_cnt_d = '0;
          shift_d   = '0;
          if (mismatch_q) begin
            phase_d          = PhHalt;
            res_o.valid      = 1'b1;
            res_o.status     = StBadType;
            res_o.record_end = 1'b1;
          end else if (shift_nx[31] || (shift_nx[30:0] > max_record_length_i)) begin
            phase_d          = PhHalt;
            res_o.valid      = 1'b1;
            res_o.status     = StTooLong;
            res_o.record_end = 1'b1;
          end else if (shift_nx[30:0] == '0) begin
            // empty payload: crc of no bytes is zero
            crc_d            = CrcInit;
            mismatch_d       = 1'b0;
            res_o.valid      = 1'b1;
            res_o.status     = (csum_q == 32'h0) ? StOk : StCsumErr;
            res_o.record_end = 1'b1;
          end else begin
            crc_d    = CrcInit;
            remain_d = shift_nx[30:0];
            phase_d  = PhPayload;
          end
        end
      end else begin
        crc_d            = crc_nx;
        remain_d         = remain_nx;
        res_o.valid      = 1'b1;
        res_o.out_byte   = in_byte_i;
        res_o.byte_valid = 1'b1;
        if (remain_nx == '0) begin
          phase_d          = PhHeader;
          hdr_cnt_d        = '0;
          shift_d          = '0;
          mismatch_d       = 1'b0;
          crc_d            = CrcInit;
          res_o.status     = (~crc_nx == csum_q) ? StOk : StCsumErr;
          res_o.record_end = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      hdr_cnt_q  <= '0;
      shift_q    <= '0;
      csum_q     <= '0;
      remain_q   <= '0;
      crc_q      <= CrcInit;
      mismatch_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      shift_q    <= shift_d;
      csum_q     <= csum_d;
      remain_q   <= remain_d;
      crc_q      <= crc_d;
      mismatch_q <= mismatch_d;
    end
  end

endmodule

### hdl/log_record_deframer_crc32c.sv
// log_record_deframer_crc32c: top level with input register, parser and output register
// depends on lrd_pkg and lrd_parser
//
//   port group   dir   handshake               contents
//   in           in    in_valid_i/in_ready_o    in_byte_i, end_of_file_i
//   out          out   out_valid_o/out_ready_i  out_byte_o, byte_valid_o,
//                                               record_status_o, record_end_o
//   cfg          in    cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// one word per cycle sustained; a word is registered in the input register, processed by the parser
// when the output slot is free or draining, and its result is registered in the output register
// the byte-wise crc update plus the header compare sit between the input and output
// registers and set the clock rate
// a stalled output holds the parser step, the input register then fills and
// drops in_ready_o; reset needs no clearing pass
`timescale 1ns / 1ps

module log_record_deframer_crc32c import lrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_file_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic [2:0]  record_status_o,
  output logic        record_end_o
);

  logic [31:0] exp_type_q;
  logic [30:0] max_len_q;

  logic        in_vq;
  logic [7:0]  in_byte_q;
  logic        in_eof_q;
  logic        out_vq;
  result_t     out_q;
  result_t     res;
  logic        adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_type_q <= '0;
      max_len_q  <= 31'h7FFF_FFFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgExpectedType: exp_type_q <= cfg_wdata_i;
        CfgMaxRecordLen: max_len_q  <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // parser steps when a word waits and the output slot is free or draining
  assign adv        = in_vq && (!out_vq || out_ready_i);
  assign in_ready_o = !in_vq || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_ready_o) begin
      in_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_eof_q  <= end_of_file_i;
    end
  end

  lrd_parser u_parser (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .step_i              (adv),
    .in_byte_i           (in_byte_q),
    .end_of_file_i       (in_eof_q),
    .expected_type_i     (exp_type_q),
    .max_record_length_i (max_len_q),
    .res_o               (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (adv && res.valid) begin
      out_vq <= 1'b1;
    end else if (out_ready_i) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_vq;
  assign out_byte_o      = out_q.out_byte;
  assign byte_valid_o    = out_q.byte_valid;
  assign record_status_o = out_q.status;
  assign record_end_o    = out_q.record_end;

endmodule

### hdl/lrd_checker.sv
// lrd_checker: port-level assertions for log_record_deframer_crc32c, bound to the top
// depends on lrd_pkg for the status codes
`timescale 1ns / 1ps

module lrd_checker import lrd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  in_byte_i,
  input logic        end_of_file_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic        byte_valid_o,
  input logic [2:0]  record_status_o,
  input logic        record_end_o
);

  // a waiting input word keeps its payload until taken
  a_in_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i)
      && $stable(end_of_file_i))
    else $error("waiting input word changed");

  // a word that does not close a record must be a plain payload byte
  a_mid_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !record_end_o |-> byte_valid_o && record_status_o == StNone)
    else $error("non-closing word is not a plain payload byte");

  // a closing word always carries a status
  a_end_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_end_o |-> record_status_o != StNone)
    else $error("closing word without status");

  // status-only words carry a zero byte and close something
  a_no_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_byte_o == 8'h00 && record_end_o)
    else $error("status-only word carries a byte");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(record_status_o) && $stable(record_end_o))
    else $error("stalled output word changed");

endmodule

bind log_record_deframer_crc32c lrd_checker u_lrd_checker (.*);

### dv/tb_log_record_deframer_crc32c.sv
// tb_log_record_deframer_crc32c: self-checking bench for the log record deframer
// depends on lrd_pkg and log_record_deframer_crc32c; holds its own deframer predictor
`timescale 1ns / 1ps

module tb_log_record_deframer_crc32c;
  import lrd_pkg::*;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhHalt    = 2'd2
  } deframe_phase_e;

  typedef enum int {
    HaltBadType,
    HaltNegLen,
    HaltTooLong
  } halt_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    status_e    status;
    logic       record_end;
  } deframe_res_t;

  // one stream word; typed rows carry a hand-written expectation
  typedef struct packed {
    logic [7:0]   data;
    logic         eof;
    logic         typed;
    logic         has;
    deframe_res_t res;
  } stim_word_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i       = 8'h00;
  logic        end_of_file_i   = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_index_i     = CfgExpectedType;
  logic [31:0] cfg_wdata_i     = 32'h0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic [2:0]  record_status_o;
  logic        record_end_o;

  log_record_deframer_crc32c i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_byte_i,
    .end_of_file_i,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .byte_valid_o,
    .record_status_o,
    .record_end_o
  );

  // predictor state, mirrors the block after reset
  deframe_phase_e pr_phase     = PhHeader;
  logic [3:0]     pr_hdr_cnt   = '0;
  logic [31:0]    pr_shift     = '0;
  logic [31:0]    pr_csum      = '0;
  logic [30:0]    pr_remaining = '0;
  logic [31:0]    pr_crc       = CrcInit;
  logic           pr_type_bad  = 1'b0;
  logic [31:0]    pr_exp_type  = 32'h0;
  logic [30:0]    pr_max_len   = 31'h7FFF_FFFF;

  deframe_res_t expected_words_q[$];
  stim_word_t   stim_q[$];
  stim_word_t   cur_word;
  int           idle_pct     = 0;
  int           stall_pct    = 0;
  int           mismatch_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[log_record_deframer_crc32c] ERROR");
    $finish;
  end

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc32cPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic deframe_res_t mk_res(input logic [7:0] d, input logic bv,
                                          input status_e st, input logic re);
    deframe_res_t r;
    r.data       = d;
    r.byte_valid = bv;
    r.status     = st;
    r.record_end = re;
    return r;
  endfunction

  function automatic void restart_header();
    pr_phase    = PhHeader;
    pr_hdr_cnt  = '0;
    pr_shift    = '0;
    pr_type_bad = 1'b0;
    pr_crc      = CrcInit;
  endfunction

  function automatic void deframe_predict(input logic [7:0] b, input logic eof,
                                          output logic has, output deframe_res_t r);
    logic [31:0] len;
    has = 1'b0;
    r   = mk_res(8'h00, 1'b0, StNone, 1'b0);
    if (pr_phase == PhHeader || pr_phase == PhPayload) begin
      if (eof) begin
        restart_header();
        pr_remaining = '0;
        has = 1'b1;
        r   = mk_res(8'h00, 1'b0, StEof, 1'b1);
      end else if (pr_phase == PhHeader) begin
        pr_shift   = {b, pr_shift[31:8]};
        pr_hdr_cnt = pr_hdr_cnt + 4'd1;
        if (pr_hdr_cnt == 4'd4) begin
          pr_csum = pr_shift;
        end else if (pr_hdr_cnt == 4'd8) begin
          pr_type_bad = (pr_shift != pr_exp_type);
        end else if (pr_hdr_cnt == 4'(HeaderBytes)) begin
          len        = pr_shift;
          pr_hdr_cnt = '0;
          pr_shift   = '0;
          has        = 1'b1;
          // type is judged before length
          if (pr_type_bad) begin
            pr_phase = PhHalt;
            r = mk_res(8'h00, 1'b0, StBadType, 1'b1);
          end else if (len[31] || len[30:0] > pr_max_len) begin
            pr_phase = PhHalt;
            r = mk_res(8'h00, 1'b0, StTooLong, 1'b1);
          end else begin
            pr_crc = CrcInit;
            if (len == 32'h0) begin
              r = mk_res(8'h00, 1'b0, (~pr_crc == pr_csum) ? StOk : StCsumErr, 1'b1);
              restart_header();
            end else begin
              has          = 1'b0;
              pr_remaining = len[30:0];
              pr_phase     = PhPayload;
            end
          end
        end
      end else begin
        pr_crc       = crc32c_byte(pr_crc, b);
        pr_remaining = pr_remaining - 31'd1;
        has          = 1'b1;
        if (pr_remaining == '0) begin
          r = mk_res(b, 1'b1, (~pr_crc == pr_csum) ? StOk : StCsumErr, 1'b1);
          restart_header();
        end else begin
          r = mk_res(b, 1'b1, StNone, 1'b0);
        end
      end
    end
  endfunction

  // input side: config mirror and prediction at each accepted word
  always @(posedge clk_i) begin : in_monitor
    logic         has;
    deframe_res_t r;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgExpectedType) pr_exp_type = cfg_wdata_i;
        else pr_max_len = cfg_wdata_i[30:0];
      end
      if (in_valid_i && in_ready_o) begin
        deframe_predict(in_byte_i, end_of_file_i, has, r);
        if (cur_word.typed) begin
          has = cur_word.has;
          r   = cur_word.res;
        end
        if (has) expected_words_q.push_back(r);
      end
    end
  end

  always @(posedge clk_i) begin : out_checker
    deframe_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words_q.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected word: byte %h valid %b status %0d end %b",
                   out_byte_o, byte_valid_o, record_status_o, record_end_o);
        mismatch_cnt++;
      end else begin
        e = expected_words_q.pop_front();
        if (out_byte_o !== e.data || byte_valid_o !== e.byte_valid ||
            record_status_o !== e.status || record_end_o !== e.record_end) begin
          if (mismatch_cnt < 10)
            $display("mismatch (exp/got): byte %h/%h valid %b/%b status %0d/%0d end %b/%b",
                     e.data, out_byte_o, e.byte_valid, byte_valid_o,
                     e.status, record_status_o, e.record_end, record_end_o);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic void add_word(input logic [7:0] d, input logic eof);
    stim_word_t w;
    w.data  = d;
    w.eof   = eof;
    w.typed = 1'b0;
    w.has   = 1'b0;
    w.res   = mk_res(8'h00, 1'b0, StNone, 1'b0);
    stim_q.push_back(w);
  endfunction

  function automatic void type_last(input logic has, input deframe_res_t r);
    stim_word_t w;
    w       = stim_q.pop_back();
    w.typed = 1'b1;
    w.has   = has;
    w.res   = r;
    stim_q.push_back(w);
  endfunction

  function automatic void add_header(input logic [31:0] csum, input logic [31:0] typ,
                                     input logic [31:0] len);
    for (int i = 0; i < 4; i++) add_word(csum[8*i +: 8], 1'b0);
    for (int i = 0; i < 4; i++) add_word(typ[8*i +: 8], 1'b0);
    for (int i = 0; i < 4; i++) add_word(len[8*i +: 8], 1'b0);
  endfunction

  task automatic send_word(input stim_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= w.data;
    end_of_file_i <= w.eof;
    cur_word      <= w;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task automatic drive_stim();
    foreach (stim_q[i]) send_word(stim_q[i]);
    stim_q.delete();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words_q.size() != 0) @(posedge clk_i);
    // headers give no word, let the pipeline settle
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] typ, input logic [30:0] maxl);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgExpectedType;
    cfg_wdata_i <= typ;
    @(posedge clk_i);
    cfg_index_i <= CfgMaxRecordLen;
    cfg_wdata_i <= {1'b0, maxl};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] typ, input logic [30:0] maxl,
                           input int idle, input int stall, input int n_items);
    int          sent;
    int          lmax;
    int          len;
    int          cut;
    logic [31:0] c;
    logic [7:0]  pay[$];
    wait_drained();
    idle_pct  = idle;
    stall_pct = stall;
    set_config(typ, maxl);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 11) == 0) begin
        add_word(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        lmax = (maxl > 24) ? 24 : int'(maxl);
        len  = $urandom_range(0, lmax);
        pay.delete();
        c = CrcInit;
        repeat (len) begin
          pay.push_back(8'($urandom_range(0, 255)));
          c = crc32c_byte(c, pay[$]);
        end
        c = ~c;
        if ($urandom_range(0, 7) == 0) c = c ^ (32'h1 << $urandom_range(0, 31));
        add_header(c, typ, 32'(len));
        foreach (pay[i]) add_word(pay[i], 1'b0);
        // truncated record, end of file lands anywhere inside it
        if ($urandom_range(0, 9) == 0) begin
          cut = $urandom_range(0, 11 + len);
          while (stim_q.size() > cut) void'(stim_q.pop_back());
          add_word(8'($urandom_range(0, 255)), 1'b1);
        end
      end
      sent += stim_q.size();
      drive_stim();
    end
  endtask

  initial begin : main
    logic [31:0] c;
    logic [31:0] typ;
    logic [30:0] maxl;
    halt_kind_e  kind;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: eof at a boundary, empty record with bad checksum, two extreme bytes
    add_word(8'h5A, 1'b1);
    type_last(1'b1, mk_res(8'h00, 1'b0, StEof, 1'b1));
    add_header(32'hFFFF_FFFF, 32'h0, 32'h0);
    type_last(1'b1, mk_res(8'h00, 1'b0, StCsumErr, 1'b1));
    c = crc32c_byte(crc32c_byte(CrcInit, 8'hFF), 8'h00);
    add_header(~c, 32'h0, 32'd2);
    add_word(8'hFF, 1'b0);
    add_word(8'h00, 1'b0);
    drive_stim();

    run_phase(32'h0,         31'h7FFF_FFFF,                0,  0,  75);
    run_phase(32'hFFFF_FFFF, 31'h0,                        75, 0,  75);
    run_phase($urandom,      31'd1,                        0,  75, 75);
    run_phase($urandom,      31'($urandom_range(2, 24)),   20, 20, 75);
    run_phase($urandom,      31'h7FFF_FFFF,                0,  0,  75);

    // a halting header ends the run, nothing comes out afterwards
    wait_drained();
    idle_pct  = 20;
    stall_pct = 20;
    typ  = $urandom;
    maxl = 31'($urandom_range(0, 30));
    set_config(typ, maxl);
    kind = halt_kind_e'($urandom_range(0, 2));
    if (kind == HaltBadType)
      add_header($urandom, typ ^ (32'h1 << $urandom_range(0, 31)), 32'hFFFF_FFFF);
    else if (kind == HaltNegLen)
      add_header($urandom, typ, {1'b1, 31'($urandom)});
    else
      add_header($urandom, typ, {1'b0, maxl} + 32'd1);
    repeat (8) add_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    drive_stim();
    wait_drained();

    if (mismatch_cnt == 0 && expected_words_q.size() == 0) begin
      $display("[log_record_deframer_crc32c] OK");
    end else begin
      $display("[log_record_deframer_crc32c] ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/lrd_pkg.sv
hdl/lrd_crc.sv
hdl/lrd_parser.sv
hdl/log_record_deframer_crc32c.sv
hdl/lrd_checker.sv
dv/tb_log_record_deframer_crc32c.sv
